>>> hdl/kbms_pkg.sv
// Shared constants, types and helper functions of the k-mer membership scorer.
package kbms_pkg;

  localparam int SET_ENTRIES = 65536;
  localparam int ADDR_W      = $clog2(SET_ENTRIES);
  localparam int MAX_K       = 8;
  localparam int WIN_W       = 2 * MAX_K;
  localparam int KW          = $clog2(MAX_K + 1);
  localparam int CFG_W       = 4;
  localparam int EPOCH_W     = 8;
  localparam int HIT_W       = 17;
  localparam int COUNT_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int IN_DATA_W   = 8;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_PAD_W   = OUT_DATA_W - HIT_W - COUNT_W;

  localparam logic [CFG_W-1:0]   KLEN_RESET = CFG_W'(8);
  localparam logic [HIT_W-1:0]   HIT_MAX    = {HIT_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_SCORE = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_t;

  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic              key_valid;
  } key_t;

  function automatic base_t base_code(input logic [CHAR_W-1:0] ch);
    base_t b;
    case (ch)
      CHAR_A:  b = '{valid: 1'b1, code: 2'd0};
      CHAR_C:  b = '{valid: 1'b1, code: 2'd1};
      CHAR_G:  b = '{valid: 1'b1, code: 2'd2};
      CHAR_T:  b = '{valid: 1'b1, code: 2'd3};
      default: b = '{valid: 1'b0, code: 2'd0};
    endcase
    return b;
  endfunction

  function automatic logic [KW-1:0] eff_k(input logic [CFG_W-1:0] len);
    logic [KW-1:0] k;
    if (len == '0) begin
      k = KW'(1);
    end else if (len > CFG_W'(MAX_K)) begin
      k = KW'(MAX_K);
    end else begin
      k = KW'(len);
    end
    return k;
  endfunction

endpackage

>>> hdl/kbms_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module kbms_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/kbms_keygen.sv
// Sliding k-mer window and fill counter that form the store key of each character.
module kbms_keygen (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic                      score,
  input  logic                      rc,
  input  logic                      last,
  input  logic [kbms_pkg::CHAR_W-1:0] base_char,
  input  logic [kbms_pkg::KW-1:0]   k,
  output kbms_pkg::key_t            key_out
);

  import kbms_pkg::*;

  logic [WIN_W-1:0]          win;
  logic [WIN_W-1:0]          win_next;
  logic [WIN_W-1:0]          mask;
  logic [KW-1:0]             filled;
  logic [KW-1:0]             filled_next;
  logic [KW:0]               sh;
  logic [1:0]                v;
  logic [WIN_W+ADDR_W-1:0]   win_ext;
  base_t                     b;

  always_comb begin
    b = base_code(base_char);
    for (int i = 0; i < MAX_K; i++) begin
      mask[2*i +: 2] = (KW'(i) < k) ? 2'b11 : 2'b00;
    end
    sh = {k - KW'(1), 1'b0};
    if (score && rc) begin
      v = b.valid ? ~b.code : 2'b00;
      win_next = ((win & mask) >> 2) | ({{(WIN_W-2){1'b0}}, v} << sh);
    end else begin
      v = b.valid ? b.code : 2'b00;
      win_next = {win[WIN_W-3:0], v};
    end
    win_next = win_next & mask;
    filled_next = (filled < k) ? filled + KW'(1) : k;
    win_ext = {{ADDR_W{1'b0}}, win_next};
    key_out.key = win_ext[ADDR_W-1:0];
    key_out.key_valid = (filled_next == k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      filled <= '0;
    end else if (step) begin
      if (last) begin
        win <= '0;
        filled <= '0;
      end else begin
        win <= win_next;
        filled <= filled_next;
      end
    end
  end

endmodule

>>> hdl/kmer_bitset_membership_scorer.sv
// Top level of the k-mer bitset membership scorer.
//
// Read characters arrive on the s_ channel, one per transaction: s_tdata holds the
// character, s_tuser holds the request type and the reverse-complement flag, and
// s_tlast marks the final character of a read. Each final character yields one
// transaction on the m_ channel with the read's hit count and the added-read count.
// The user writes the key length on the cfg_ channel while idle; it is not enforced.
//
// The model and seen memories are read in the accept cycle and written back in the
// next one, so s_tready is low in the write-back cycle. A result is registered in
// the write-back cycle of its final character, once the output register is free.
// Seen marks carry a per-read epoch, so no clearing is needed between reads.
//
// After reset both memories are cleared at all 65536 addresses with s_tready low.
// When the 8-bit epoch wraps, after every 255 reads, the seen memory is cleared
// again by a pass over all 65536 addresses. Characters are still accepted while
// a result waits on a stalled m_ channel; a further final character holds in the
// write-back cycle until the output register is free.
module kmer_bitset_membership_scorer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kbms_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] base_char
  input  logic [kbms_pkg::IN_USER_W-1:0]  s_tuser,   // [0] req_type, [1] reverse_comp
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kbms_pkg::OUT_DATA_W-1:0] m_tdata,   // [16:0] hit_count, [48:17] read_count
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kbms_pkg::CFG_W-1:0]      cfg_data
);

  import kbms_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR_ALL,
    S_CLEAR_SEEN,
    S_IDLE,
    S_UPD
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [EPOCH_W-1:0] epoch;
  logic [EPOCH_W-1:0] epoch_inc;
  logic [HIT_W-1:0]   hit;
  logic [HIT_W-1:0]   hit_next;
  logic [COUNT_W-1:0] reads;
  logic [COUNT_W-1:0] reads_next;
  logic [CFG_W-1:0]   klen;
  logic [ADDR_W-1:0]  key_q;
  logic               key_valid_q;
  logic               score_q;
  logic               last_q;
  logic               accept;
  logic               advance;
  logic               new_hit;
  key_t               key;

  logic               model_we;
  logic [ADDR_W-1:0]  model_waddr;
  logic               model_wdata;
  logic               model_rd;
  logic               seen_we;
  logic [ADDR_W-1:0]  seen_waddr;
  logic [EPOCH_W-1:0] seen_wdata;
  logic [EPOCH_W-1:0] seen_rd;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  kbms_keygen u_keygen (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .score     (s_tuser[0]),
    .rc        (s_tuser[1]),
    .last      (s_tlast),
    .base_char (s_tdata[CHAR_W-1:0]),
    .k         (eff_k(klen)),
    .key_out   (key)
  );

  kbms_ram #(.ADDR_W(ADDR_W), .DATA_W(1)) u_model_ram (
    .clk   (clk),
    .we    (model_we),
    .waddr (model_waddr),
    .wdata (model_wdata),
    .re    (accept),
    .raddr (key.key),
    .rdata (model_rd)
  );

  kbms_ram #(.ADDR_W(ADDR_W), .DATA_W(EPOCH_W)) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .re    (accept),
    .raddr (key.key),
    .rdata (seen_rd)
  );

  always_comb begin
    model_we    = 1'b0;
    model_waddr = key_q;
    model_wdata = 1'b1;
    seen_we     = 1'b0;
    seen_waddr  = key_q;
    seen_wdata  = epoch;
    case (state)
      S_CLEAR_ALL: begin
        model_we    = 1'b1;
        model_waddr = clr_addr;
        model_wdata = 1'b0;
        seen_we     = 1'b1;
        seen_waddr  = clr_addr;
        seen_wdata  = EPOCH_NONE;
      end
      S_CLEAR_SEEN: begin
        seen_we    = 1'b1;
        seen_waddr = clr_addr;
        seen_wdata = EPOCH_NONE;
      end
      S_UPD: begin
        if (key_valid_q) begin
          if (score_q == REQ_ADD) begin
            model_we = 1'b1;
          end else if (seen_rd != epoch) begin
            seen_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    new_hit    = (score_q == REQ_SCORE) && key_valid_q && (seen_rd != epoch) && model_rd
                 && (hit != HIT_MAX);
    hit_next   = hit + HIT_W'(new_hit);
    reads_next = reads + COUNT_W'(score_q == REQ_ADD);
    epoch_inc  = epoch + EPOCH_W'(1);
    advance    = (state == S_UPD) && (!last_q || !m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR_ALL;
      clr_addr <= '0;
      epoch    <= EPOCH_FIRST;
      hit      <= '0;
      reads    <= '0;
      klen     <= KLEN_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        klen <= cfg_data;
      end
      if (advance && last_q) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR_ALL, S_CLEAR_SEEN: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == {ADDR_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            key_q       <= key.key;
            key_valid_q <= key.key_valid;
            score_q     <= s_tuser[0];
            last_q      <= s_tlast;
            state       <= S_UPD;
          end
        end
        S_UPD: begin
          if (advance) begin
            if (last_q) begin
              hit      <= '0;
              reads    <= reads_next;
              m_tdata  <= {{OUT_PAD_W{1'b0}}, reads_next,
                           (score_q == REQ_SCORE) ? hit_next : {HIT_W{1'b0}}};
              if (epoch_inc == EPOCH_NONE) begin
                epoch <= EPOCH_FIRST;
                state <= S_CLEAR_SEEN;
              end else begin
                epoch <= epoch_inc;
                state <= S_IDLE;
              end
            end else begin
              hit   <= hit_next;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/kbms_checker.sv
// Port-level checker of the k-mer membership scorer and its bind to the top level.
module kbms_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [kbms_pkg::IN_USER_W-1:0]  s_tuser,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [kbms_pkg::OUT_DATA_W-1:0] m_tdata
);

  import kbms_pkg::*;

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("s_tready high right after reset");

  a_one_per_update: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted during write-back cycle");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
    else $error("result without a final character");

  a_add_read_no_hits: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && $past(s_tuser[0] == REQ_ADD, 2)) |-> (m_tdata[HIT_W-1:0] == '0))
    else $error("nonzero hit count for an add read");

  a_output_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind kmer_bitset_membership_scorer kbms_checker u_kbms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
